// ===== hw/rtl/sbc_pkg.sv =====
// Shared types and constants of the swept box collision pipeline.
`default_nettype none
package sbc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned HALF_W  = 31;
  localparam int unsigned GAP_W   = 35;
  localparam int unsigned MAG_W   = 34;
  localparam int unsigned NUM_W   = MAG_W + 16;
  localparam int unsigned DEN_W   = 32;
  localparam int unsigned NDIV    = 33;
  localparam int unsigned TIME_W  = 34;
  localparam int unsigned NST     = NDIV + 5;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_MOVER_HALF_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_MOVER_HALF_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_MOVER_HALF_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_HALF_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_TARGET_HALF_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_TARGET_HALF_Z = 3'd5;

  localparam logic [HALF_W-1:0] HALF_RESET = 31'd32768;

  localparam logic signed [TIME_W-1:0] T_NEG_INF = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] T_POS_INF = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] T_MIN     = -(34'sd1 <<< 31);
  localparam logic signed [TIME_W-1:0] T_MAX     = (34'sd1 <<< 31) - 34'sd1;
  localparam logic signed [TIME_W-1:0] T_ONE     = 34'sd65536;
  localparam logic [16:0]              TIME_ONE  = 17'd65536;

  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;
  localparam logic [1:0] NRM_ZERO = 2'b00;

  // sideband that travels with an item through the divider stages
  typedef struct packed {
    logic [2:0] vz;
    logic [2:0] cneg;
    logic       allz;
  } side_t;

  // result of one divider, before sign and saturation
  typedef struct packed {
    logic [NDIV-1:0] q;
    logic            rnz;
    logic            neg;
    logic            ovf;
  } quot_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sbc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sbc_div
  import sbc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [NDIV-1:0]  adv,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic             neg,
  output quot_t                 res
);

  logic [DEN_W-1:0] rem_r [NDIV];
  logic [NDIV-1:0]  low_r [NDIV];
  logic [NDIV-1:0]  q_r   [NDIV];
  logic [DEN_W-1:0] d_r   [NDIV];
  logic             neg_r [NDIV];
  logic             ovf_r [NDIV];

  logic [DEN_W-1:0] rem_in  [NDIV];
  logic [NDIV-1:0]  low_in  [NDIV];
  logic [NDIV-1:0]  q_in    [NDIV];
  logic [DEN_W-1:0] d_in    [NDIV];
  logic             neg_in  [NDIV];
  logic             ovf_in  [NDIV];
  logic [DEN_W-1:0] rem_nxt [NDIV];
  logic [NDIV-1:0]  q_nxt   [NDIV];

  logic [NUM_W-NDIV-1:0] top_bits;
  assign top_bits = num[NUM_W-1:NDIV];

  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      logic [DEN_W:0] rem2;
      logic           ge;
      if (k == 0) begin
        rem_in[k] = DEN_W'(top_bits);
        low_in[k] = num[NDIV-1:0];
        q_in[k]   = '0;
        d_in[k]   = den;
        neg_in[k] = neg;
        ovf_in[k] = (DEN_W'(top_bits) >= den);
      end else begin
        rem_in[k] = rem_r[k-1];
        low_in[k] = low_r[k-1];
        q_in[k]   = q_r[k-1];
        d_in[k]   = d_r[k-1];
        neg_in[k] = neg_r[k-1];
        ovf_in[k] = ovf_r[k-1];
      end
      rem2       = {rem_in[k], low_in[k][NDIV-1-k]};
      ge         = (rem2 >= {1'b0, d_in[k]});
      rem_nxt[k] = ge ? DEN_W'(rem2 - {1'b0, d_in[k]}) : rem2[DEN_W-1:0];
      q_nxt[k]   = {q_in[k][NDIV-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDIV; k++) begin
      if (adv[k]) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_in[k];
        q_r[k]   <= q_nxt[k];
        d_r[k]   <= d_in[k];
        neg_r[k] <= neg_in[k];
        ovf_r[k] <= ovf_in[k];
      end
    end
  end

  assign res.q   = q_r[NDIV-1];
  assign res.rnz = (rem_r[NDIV-1] != '0);
  assign res.neg = neg_r[NDIV-1];
  assign res.ovf = ovf_r[NDIV-1];

endmodule
`default_nettype wire

// ===== hw/rtl/swept_box_collision.sv =====
// Swept box collision: moving AABB against static AABB, fully pipelined.
// Depth: 38 register stages; a stall on the result side holds the words in flight.
// Throughput: one word per cycle while the result side does not stall; the 33-stage
// restoring dividers (one per gap, six in all) set the depth.
// Reset (rst_n low, synchronous): pipeline empties, half extents go to 0.5.
`default_nettype none
module swept_box_collision
  import sbc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [IDX_W-1:0]          cfg_index,
  input  wire logic [HALF_W-1:0]         cfg_wdata,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire logic signed [COORD_W-1:0] in_mover_x,
  input  wire logic signed [COORD_W-1:0] in_mover_y,
  input  wire logic signed [COORD_W-1:0] in_mover_z,
  input  wire logic signed [COORD_W-1:0] in_target_x,
  input  wire logic signed [COORD_W-1:0] in_target_y,
  input  wire logic signed [COORD_W-1:0] in_target_z,
  input  wire logic signed [COORD_W-1:0] in_velocity_x,
  input  wire logic signed [COORD_W-1:0] in_velocity_y,
  input  wire logic signed [COORD_W-1:0] in_velocity_z,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      logic                      out_hit,
  output      logic [16:0]               out_hit_time,
  output      logic signed [1:0]         out_normal_x,
  output      logic signed [1:0]         out_normal_y,
  output      logic signed [1:0]         out_normal_z
);

  // Stage map: 0 gaps, 1 magnitudes, 2..NDIV+1 dividers, NDIV+2 signed
  // times, NDIV+3 max/min, NDIV+4 output register.
  localparam int unsigned S_FIX = NDIV + 2;
  localparam int unsigned S_CMP = NDIV + 3;
  localparam int unsigned S_OUT = NDIV + 4;

  // ---------------- configuration registers ----------------
  logic [HALF_W-1:0] mh_r [3];
  logic [HALF_W-1:0] th_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        mh_r[a] <= HALF_RESET;
        th_r[a] <= HALF_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVER_HALF_X:  mh_r[0] <= cfg_wdata;
        REG_MOVER_HALF_Y:  mh_r[1] <= cfg_wdata;
        REG_MOVER_HALF_Z:  mh_r[2] <= cfg_wdata;
        REG_TARGET_HALF_X: th_r[0] <= cfg_wdata;
        REG_TARGET_HALF_Y: th_r[1] <= cfg_wdata;
        REG_TARGET_HALF_Z: th_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- valid/enable chain ----------------
  // A stage loads when it is empty or the stage after it moves on, so
  // bubbles collapse and a stall at the output holds every full stage.
  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          vld_r[i] <= (i == 0) ? in_valid : vld_r[i-1];
        end
      end
    end
  end

  // ---------------- stage 0: gaps ----------------
  logic signed [COORD_W-1:0] a_in [3];
  logic signed [COORD_W-1:0] b_in [3];
  logic signed [COORD_W-1:0] v_in [3];
  logic signed [GAP_W-1:0]   close_nxt [3];
  logic signed [GAP_W-1:0]   far_nxt   [3];
  logic signed [GAP_W-1:0]   close_r   [3];
  logic signed [GAP_W-1:0]   far_r     [3];
  logic signed [COORD_W-1:0] v0_r      [3];

  assign a_in[0] = in_mover_x;
  assign a_in[1] = in_mover_y;
  assign a_in[2] = in_mover_z;
  assign b_in[0] = in_target_x;
  assign b_in[1] = in_target_y;
  assign b_in[2] = in_target_z;
  assign v_in[0] = in_velocity_x;
  assign v_in[1] = in_velocity_y;
  assign v_in[2] = in_velocity_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [GAP_W-1:0] aa, bb, ae, be;
      aa = GAP_W'(a_in[a]);
      bb = GAP_W'(b_in[a]);
      ae = $signed({{(GAP_W-HALF_W){1'b0}}, mh_r[a]});
      be = $signed({{(GAP_W-HALF_W){1'b0}}, th_r[a]});
      if (v_in[a] > 0) begin
        close_nxt[a] = (bb - be) - (aa + ae);
        far_nxt[a]   = (bb + be) - (aa - ae);
      end else begin
        close_nxt[a] = (bb + be) - (aa - ae);
        far_nxt[a]   = (bb - be) - (aa + ae);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        close_r[a] <= close_nxt[a];
        far_r[a]   <= far_nxt[a];
        v0_r[a]    <= v_in[a];
      end
    end
  end

  // ---------------- stage 1: magnitudes for the dividers ----------------
  logic [NUM_W-1:0] cnum_r [3];
  logic [NUM_W-1:0] fnum_r [3];
  logic [DEN_W-1:0] den_r  [3];
  logic             cneg_r [3];
  logic             fneg_r [3];
  side_t            side_r [1:S_FIX-1];
  side_t            side0;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      side0.vz[a]   = (v0_r[a] == '0);
      side0.cneg[a] = close_r[a][GAP_W-1];
    end
    side0.allz = &side0.vz;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        logic [MAG_W-1:0] cm, fm;
        cm = close_r[a][GAP_W-1] ? MAG_W'(-close_r[a]) : MAG_W'(close_r[a]);
        fm = far_r[a][GAP_W-1] ? MAG_W'(-far_r[a]) : MAG_W'(far_r[a]);
        cnum_r[a] <= {cm, 16'h0000};
        fnum_r[a] <= {fm, 16'h0000};
        den_r[a]  <= v0_r[a][COORD_W-1] ? DEN_W'(-v0_r[a]) : DEN_W'(v0_r[a]);
        cneg_r[a] <= close_r[a][GAP_W-1] ^ v0_r[a][COORD_W-1];
        fneg_r[a] <= far_r[a][GAP_W-1] ^ v0_r[a][COORD_W-1];
      end
    end
  end

  // sideband rides alongside; stage 0 has none, index 1 is the magnitude stage
  always_ff @(posedge clk) begin
    for (int i = 1; i < S_FIX; i++) begin
      if (en[i]) begin
        side_r[i] <= (i == 1) ? side0 : side_r[i-1];
      end
    end
  end

  // ---------------- dividers ----------------
  quot_t cq [3];
  quot_t fq [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sbc_div u_close (
      .clk (clk),
      .adv (en[2 +: NDIV]),
      .num (cnum_r[a]),
      .den (den_r[a]),
      .neg (cneg_r[a]),
      .res (cq[a])
    );
    sbc_div u_far (
      .clk (clk),
      .adv (en[2 +: NDIV]),
      .num (fnum_r[a]),
      .den (den_r[a]),
      .neg (fneg_r[a]),
      .res (fq[a])
    );
  end

  // ---------------- stage S_FIX: floor, sign and saturate ----------------
  // m is an unsigned magnitude that can reach 2^33; compare it unsigned
  function automatic logic signed [TIME_W-1:0] fix_time(quot_t qv);
    logic [TIME_W-1:0] m;
    logic signed [TIME_W-1:0] t;
    m = TIME_W'(qv.q) + TIME_W'(qv.rnz);
    if (!qv.neg) begin
      t = (qv.ovf || qv.q[NDIV-1] || qv.q[NDIV-2]) ? T_MAX : $signed(TIME_W'(qv.q));
    end else begin
      t = (qv.ovf || m > TIME_W'(-T_MIN)) ? T_MIN : -$signed(m);
    end
    return t;
  endfunction

  logic signed [TIME_W-1:0] ent_r [3];
  logic signed [TIME_W-1:0] lev_r [3];
  logic [2:0]               fcneg_r;
  logic                     fallz_r;

  always_ff @(posedge clk) begin
    if (en[S_FIX]) begin
      for (int a = 0; a < 3; a++) begin
        ent_r[a] <= side_r[S_FIX-1].vz[a] ? T_NEG_INF : fix_time(cq[a]);
        lev_r[a] <= side_r[S_FIX-1].vz[a] ? T_POS_INF : fix_time(fq[a]);
      end
      fcneg_r <= side_r[S_FIX-1].cneg;
      fallz_r <= side_r[S_FIX-1].allz;
    end
  end

  // ---------------- stage S_CMP: largest entry, smallest exit, face ----------------
  logic signed [TIME_W-1:0] enter_r;
  logic signed [TIME_W-1:0] leave_r;
  logic                     miss_r;
  logic [1:0]               nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (en[S_CMP]) begin
      logic signed [TIME_W-1:0] emax, lmin;
      logic selx, sely;
      emax = (ent_r[0] > ent_r[1]) ? ent_r[0] : ent_r[1];
      if (ent_r[2] > emax) emax = ent_r[2];
      lmin = (lev_r[0] < lev_r[1]) ? lev_r[0] : lev_r[1];
      if (lev_r[2] < lmin) lmin = lev_r[2];
      selx = (ent_r[0] > ent_r[1]) && (ent_r[0] >= ent_r[2]);
      sely = !selx && (ent_r[1] >= ent_r[0]) && (ent_r[1] > ent_r[2]);
      enter_r <= emax;
      leave_r <= lmin;
      // drop: no motion, all entries in the past, or an entry beyond the step
      miss_r  <= fallz_r ||
                 (ent_r[0] < 0 && ent_r[1] < 0 && ent_r[2] < 0) ||
                 ent_r[0] > T_ONE || ent_r[1] > T_ONE || ent_r[2] > T_ONE;
      nx_r <= selx ? (fcneg_r[0] ? NRM_POS : NRM_NEG) : NRM_ZERO;
      ny_r <= sely ? (fcneg_r[1] ? NRM_POS : NRM_NEG) : NRM_ZERO;
      nz_r <= (!selx && !sely) ? (fcneg_r[2] ? NRM_POS : NRM_NEG) : NRM_ZERO;
    end
  end

  // ---------------- stage S_OUT: output register ----------------
  logic        hit_nxt;
  logic        hit_r;
  logic [16:0] time_r;
  logic [1:0]  onx_r, ony_r, onz_r;

  assign hit_nxt = !miss_r && !(enter_r > leave_r);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      hit_r  <= hit_nxt;
      time_r <= hit_nxt ? enter_r[16:0] : TIME_ONE;
      onx_r  <= hit_nxt ? nx_r : NRM_ZERO;
      ony_r  <= hit_nxt ? ny_r : NRM_ZERO;
      onz_r  <= hit_nxt ? nz_r : NRM_ZERO;
    end
  end

  assign out_valid    = vld_r[S_OUT];
  assign out_hit      = hit_r;
  assign out_hit_time = time_r;
  assign out_normal_x = $signed(onx_r);
  assign out_normal_y = $signed(ony_r);
  assign out_normal_z = $signed(onz_r);

endmodule
`default_nettype wire

// ===== tb/sv/swept_box_collision_checker.sv =====
// Checker for the swept box collision block: predicts each result word and compares.
`timescale 1ns / 100ps
module swept_box_collision_checker
  import sbc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [IDX_W-1:0]          cfg_index,
  input  wire logic [HALF_W-1:0]         cfg_wdata,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic signed [COORD_W-1:0] in_mover_x,
  input  wire logic signed [COORD_W-1:0] in_mover_y,
  input  wire logic signed [COORD_W-1:0] in_mover_z,
  input  wire logic signed [COORD_W-1:0] in_target_x,
  input  wire logic signed [COORD_W-1:0] in_target_y,
  input  wire logic signed [COORD_W-1:0] in_target_z,
  input  wire logic signed [COORD_W-1:0] in_velocity_x,
  input  wire logic signed [COORD_W-1:0] in_velocity_y,
  input  wire logic signed [COORD_W-1:0] in_velocity_z,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic                      out_hit,
  input  wire logic [16:0]               out_hit_time,
  input  wire logic signed [1:0]         out_normal_x,
  input  wire logic signed [1:0]         out_normal_y,
  input  wire logic signed [1:0]         out_normal_z,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic        hit;
    logic [16:0] hit_time;
    logic [1:0]  nx;
    logic [1:0]  ny;
    logic [1:0]  nz;
  } contact_t;

  localparam longint LT_NEG_INF = -(longint'(1) << 40);
  localparam longint LT_POS_INF = longint'(1) << 40;
  localparam longint LT_MIN     = -(longint'(1) << 31);
  localparam longint LT_MAX     = (longint'(1) << 31) - 1;
  localparam longint LT_ONE     = 65536;

  logic [HALF_W-1:0] mover_half[3];
  logic [HALF_W-1:0] target_half[3];
  contact_t          contacts_due[$];

  assign pending = contacts_due.size();

  // floor(gap * 2^16 / v), clamped to the Q16.16 range
  function automatic longint sweep_time(longint gap, longint v);
    longint n, q, r;
    n = gap * 65536;
    q = n / v;
    r = n % v;
    if (r != 0 && ((r < 0) != (v < 0))) q--;
    if (q < LT_MIN) q = LT_MIN;
    if (q > LT_MAX) q = LT_MAX;
    return q;
  endfunction

  function automatic contact_t predict_contact(
    input logic signed [COORD_W-1:0] m[3], input logic signed [COORD_W-1:0] t[3],
    input logic signed [COORD_W-1:0] vel[3]);
    contact_t c;
    longint   close_gap[3], enter_t[3], leave_t[3];
    longint   a, ae, b, be, v, far_gap, enter, leave;
    logic     ok;
    c = '{hit: 1'b0, hit_time: TIME_ONE, nx: NRM_ZERO, ny: NRM_ZERO, nz: NRM_ZERO};
    if (vel[0] == 0 && vel[1] == 0 && vel[2] == 0) return c;
    for (int i = 0; i < 3; i++) begin
      a  = longint'(m[i]);
      b  = longint'(t[i]);
      ae = longint'({1'b0, mover_half[i]});
      be = longint'({1'b0, target_half[i]});
      v  = longint'(vel[i]);
      if (v > 0) begin
        close_gap[i] = (b - be) - (a + ae);
        far_gap      = (b + be) - (a - ae);
      end else begin
        close_gap[i] = (b + be) - (a - ae);
        far_gap      = (b - be) - (a + ae);
      end
      if (v == 0) begin
        enter_t[i] = LT_NEG_INF;
        leave_t[i] = LT_POS_INF;
      end else begin
        enter_t[i] = sweep_time(close_gap[i], v);
        leave_t[i] = sweep_time(far_gap, v);
      end
    end
    enter = enter_t[0] > enter_t[1] ? enter_t[0] : enter_t[1];
    if (enter_t[2] > enter) enter = enter_t[2];
    leave = leave_t[0] < leave_t[1] ? leave_t[0] : leave_t[1];
    if (leave_t[2] < leave) leave = leave_t[2];
    ok = !(enter > leave || (enter_t[0] < 0 && enter_t[1] < 0 && enter_t[2] < 0) ||
           enter_t[0] > LT_ONE || enter_t[1] > LT_ONE || enter_t[2] > LT_ONE);
    if (!ok) return c;
    // y beats x on a tie, x beats z and z beats y; a three-way tie goes to z
    if (enter_t[0] > enter_t[1] && enter_t[0] >= enter_t[2])
      c.nx = close_gap[0] < 0 ? NRM_POS : NRM_NEG;
    else if (enter_t[1] >= enter_t[0] && enter_t[1] > enter_t[2])
      c.ny = close_gap[1] < 0 ? NRM_POS : NRM_NEG;
    else
      c.nz = close_gap[2] < 0 ? NRM_POS : NRM_NEG;
    c.hit      = 1'b1;
    c.hit_time = enter[16:0];
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: result word field %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    logic signed [COORD_W-1:0] m[3], t[3], vel[3];
    contact_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        mover_half[i]  <= HALF_RESET;
        target_half[i] <= HALF_RESET;
      end
      contacts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MOVER_HALF_X:  mover_half[0]  <= cfg_wdata;
          REG_MOVER_HALF_Y:  mover_half[1]  <= cfg_wdata;
          REG_MOVER_HALF_Z:  mover_half[2]  <= cfg_wdata;
          REG_TARGET_HALF_X: target_half[0] <= cfg_wdata;
          REG_TARGET_HALF_Y: target_half[1] <= cfg_wdata;
          REG_TARGET_HALF_Z: target_half[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        m   = '{in_mover_x, in_mover_y, in_mover_z};
        t   = '{in_target_x, in_target_y, in_target_z};
        vel = '{in_velocity_x, in_velocity_y, in_velocity_z};
        contacts_due.push_back(predict_contact(m, t, vel));
      end
      if (out_valid && !out_stall) begin
        if (contacts_due.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = contacts_due.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_hit_time !== want.hit_time)
            report_mismatch("hit_time", out_hit_time, want.hit_time);
          if (out_normal_x !== want.nx) report_mismatch("normal_x", out_normal_x, want.nx);
          if (out_normal_y !== want.ny) report_mismatch("normal_y", out_normal_y, want.ny);
          if (out_normal_z !== want.nz) report_mismatch("normal_z", out_normal_z, want.nz);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_swept_box_collision.sv =====
// Testbench top for the swept box collision block: stimulus, stalls and verdict.
`timescale 1ns / 100ps
module tb_swept_box_collision;
  import sbc_pkg::*;

  // index past the six half-extent registers; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 60;
  localparam int RANDOM_WORDS = 60;   // per config phase, six phases
  localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] ONE   = 32'sd65536;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [IDX_W-1:0]          cfg_index;
  logic [HALF_W-1:0]         cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_mover_x, in_mover_y, in_mover_z;
  logic signed [COORD_W-1:0] in_target_x, in_target_y, in_target_z;
  logic signed [COORD_W-1:0] in_velocity_x, in_velocity_y, in_velocity_z;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_hit;
  logic [16:0]               out_hit_time;
  logic signed [1:0]         out_normal_x, out_normal_y, out_normal_z;
  int                        fail_count;
  int                        pending;
  int                        idle_cycles = 0;
  bit                        no_gaps;

  swept_box_collision DUT (.*);
  swept_box_collision_checker u_checker (.*);

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none at all while no_gaps is set.
  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure: random stall runs, with stall-free stretches.
  initial begin
    out_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else begin
        out_stall <= $urandom_range(0, 2) == 0;
        repeat (gap_len() + 1) @(posedge clk);
      end
    end
  end

  // Drive one word and hold it until the block takes it.
  task automatic send_word(input logic signed [31:0] mx, my, mz, tx, ty, tz, vx, vy, vz);
    int  gap;
    bit  taken;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mover_x    <= mx;  in_mover_y    <= my;  in_mover_z    <= mz;
    in_target_x   <= tx;  in_target_y   <= ty;  in_target_z   <= tz;
    in_velocity_x <= vx;  in_velocity_y <= vy;  in_velocity_z <= vz;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and wait for every outstanding result word; wait for the clock
  // first so the word taken at this edge is already counted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_halves(input logic [HALF_W-1:0] mx, my, mz, tx, ty, tz);
    logic [HALF_W-1:0] vals[6];
    vals = '{mx, my, mz, tx, ty, tz};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    // out-of-range index: must not land anywhere
    cfg_index <= REG_UNUSED;
    cfg_wdata <= {HALF_W{1'b1}};
    @(posedge clk);
    cfg_index <= REG_UNUSED + 3'd1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] near_coord(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly sweeps aimed at the target, with occasional zero axes;
  // the rest are raw 32-bit noise words.
  task automatic send_random();
    logic signed [31:0] m[3], t[3], v[3];
    longint             aim;
    int                 kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 15) begin
        m[i] = $urandom; t[i] = $urandom; v[i] = $urandom;
        if ($urandom_range(0, 3) == 0) v[i] = 0;
      end else begin
        m[i] = near_coord(1 << 19);
        v[i] = ($urandom_range(0, 4) == 0) ? 32'sd0 : near_coord(1 << 18);
        aim  = longint'(v[i]) * longint'($urandom_range(0, 96)) / 64;
        t[i] = 32'(longint'(m[i]) + aim + longint'(near_coord(1 << 16)));
        if (kind < 25 && $urandom_range(0, 1)) t[i] = m[i] + (v[i] >>> 1);
      end
    end
    send_word(m[0], m[1], m[2], t[0], t[1], t[2], v[0], v[1], v[2]);
  endtask

  task automatic send_directed();
    // no motion at all
    send_word(0, 0, 0, ONE, 0, 0, 0, 0, 0);
    // head-on along each axis, both directions: entry at one half
    send_word(0, 0, 0, 2 * ONE, 0, 0, 2 * ONE, 0, 0);
    send_word(0, 0, 0, -2 * ONE, 0, 0, -2 * ONE, 0, 0);
    send_word(0, 0, 0, 0, 2 * ONE, 0, 0, 2 * ONE, 0);
    send_word(0, 0, 0, 0, -2 * ONE, 0, 0, -2 * ONE, 0);
    send_word(0, 0, 0, 0, 0, 2 * ONE, 0, 0, 2 * ONE);
    send_word(0, 0, 0, 0, 0, -2 * ONE, 0, 0, -2 * ONE);
    // entry exactly at one, and just past it
    send_word(0, 0, 0, 2 * ONE, 0, 0, ONE, 0, 0);
    send_word(0, 0, 0, 2 * ONE + 1, 0, 0, ONE, 0, 0);
    // touching at the start: entry zero
    send_word(0, 0, 0, ONE, 0, 0, ONE, 0, 0);
    // already overlapping: every entry negative
    send_word(0, 0, 0, ONE / 2, 0, 0, ONE, 0, 0);
    // x and y tie (y wins), then x/y/z all tie (z wins), then x and z tie
    send_word(0, 0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0);
    send_word(0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE);
    send_word(0, 0, 0, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE);
    // sideways offset on an axis with no motion, and moving away
    send_word(0, 0, 0, ONE, 3 * ONE, 0, 2 * ONE, 0, 0);
    send_word(0, 0, 0, 2 * ONE, 0, 0, -ONE, 0, 0);
    // field extremes: saturated quotients, tiny velocities
    send_word(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 1, 1, 1);
    send_word(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, -1, -1, -1);
    send_word(S_MIN, 0, 0, S_MAX, 0, 0, S_MAX, 0, 0);
    send_word(S_MAX, 0, 0, S_MIN, 0, 0, S_MIN, 0, 0);
    send_word(0, S_MIN, 0, 0, S_MAX, 0, 0, S_MAX, 0);
    send_word(0, 0, S_MAX, 0, 0, S_MIN, 0, 0, S_MIN);
    send_word(-1, -1, -1, -1, -1, -1, S_MIN, S_MAX, -1);
  endtask

  initial begin
    logic [HALF_W-1:0] h[6];
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MOVER_HALF_X;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    {in_mover_x, in_mover_y, in_mover_z}          <= '0;
    {in_target_x, in_target_y, in_target_z}       <= '0;
    {in_velocity_x, in_velocity_y, in_velocity_z} <= '0;
    no_gaps     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset halves first, then each phase with its own extents
    send_directed();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: h = '{default: '0};
        1: h = '{default: {HALF_W{1'b1}}};
        2: h = '{HALF_W'(0), {HALF_W{1'b1}}, HALF_W'(1), HALF_W'(32768),
                 HALF_W'(65536), {HALF_W{1'b1}}};
        default: foreach (h[i]) h[i] = ($urandom_range(0, 9) == 0) ?
                                       HALF_W'($urandom) : HALF_W'($urandom_range(0, 1 << 18));
      endcase
      write_halves(h[0], h[1], h[2], h[3], h[4], h[5]);
      no_gaps = (phase == 3);
      if (phase < 3) send_directed();
      repeat (RANDOM_WORDS) send_random();
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_div.sv
hw/rtl/swept_box_collision.sv
tb/sv/swept_box_collision_checker.sv
tb/sv/tb_swept_box_collision.sv
